>>> design/afs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg: shared definitions for the animation frame sequencer
// Default widths, register indexes, command codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int unsigned TIME_BITS_DEF  = 16;
  localparam int unsigned FRAME_BITS_DEF = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT  = 2'd2;

  // Item command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic restart;   // clear all animation state
    logic advance;   // start an advance item
    logic div_step;  // one restoring division step
    logic update;    // fold the cycle count, load the frame division
    logic frame_wr;  // write the clamped frame quotient
    logic out_load;  // capture the result item
  } afs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;       // cycle limit is set and has been reached
    logic finishing;  // the current advance reaches the cycle limit
  } afs_status_t;

endpackage

>>> design/afs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_datapath: configuration, animation state and shared serial divider
// Holds the registers, the accumulator and counters, one bit-serial restoring
// divider used for both divisions, the frame multiplier and the result item.
// ----------------------------------------------------------------------------
module afs_datapath #(
  parameter int unsigned TIME_BITS  = afs_pkg::TIME_BITS_DEF,
  parameter int unsigned FRAME_BITS = afs_pkg::FRAME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [((TIME_BITS > FRAME_BITS + 1) ? TIME_BITS : FRAME_BITS + 1)-1:0]
                                         cfg_wdata_i,
  input  logic [TIME_BITS-1:0]           elapsed_ticks_i,
  input  afs_pkg::afs_cmd_t              cmd_i,
  output afs_pkg::afs_status_t           status_o,
  output logic [FRAME_BITS-1:0]          frame_index_o,
  output logic                           frame_changed_o,
  output logic                           finished_o
);

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned FB = FRAME_BITS;
  localparam int unsigned QB = FB + 1;        // frame quotient bits
  localparam int unsigned DW = TB + FB + 1;   // divider dividend width
  localparam logic [FB:0] FRAMES_MAX = {1'b1, {FB{1'b0}}};

  logic [FB:0]    frame_count_q;
  logic [TB-1:0]  cycle_period_q;
  logic [TB-1:0]  cycle_limit_q;

  logic [TB-1:0]  accu_q, accu_d;
  logic [TB-1:0]  cycles_q, cycles_d;
  logic [FB-1:0]  cur_q, cur_d;
  logic [FB-1:0]  prev_q, prev_d;

  logic [TB-1:0]  rem_q, rem_d;
  logic [DW-1:0]  quo_q, quo_d;

  logic [FB-1:0]  out_frame_q;
  logic           out_changed_q;
  logic           out_finished_q;

  logic [FB:0]    frames_eff;
  logic [FB:0]    frames_m1;
  logic [TB-1:0]  period_eff;
  logic           done;
  logic [TB:0]    sum;
  logic [TB+1:0]  total;
  logic [TB-1:0]  total_sat;
  logic           finishing;
  logic [TB+1:0]  trial;
  logic [TB:0]    shifted;
  logic [DW-1:0]  prod;
  logic [QB-1:0]  f_raw;
  logic [QB-1:0]  f_clamped;

  // Effective configuration.
  always_comb begin
    if (frame_count_q == '0) begin
      frames_eff = (FB + 1)'(1);
    end else if (frame_count_q > FRAMES_MAX) begin
      frames_eff = FRAMES_MAX;
    end else begin
      frames_eff = frame_count_q;
    end
  end

  assign frames_m1  = frames_eff - (FB + 1)'(1);
  assign period_eff = (cycle_period_q == '0) ? TB'(1) : cycle_period_q;
  assign done       = (cycle_limit_q != '0) && (cycles_q >= cycle_limit_q);

  assign sum       = {1'b0, accu_q} + {1'b0, elapsed_ticks_i};
  assign total     = {2'b00, cycles_q} + {1'b0, quo_q[TB:0]};
  assign total_sat = (total[TB+1:TB] != 2'b00) ? {TB{1'b1}} : total[TB-1:0];
  assign finishing = (cycle_limit_q != '0) && (total >= {2'b00, cycle_limit_q});

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, period_eff};

  assign prod = {{(FB + 1){1'b0}}, rem_q} * {{TB{1'b0}}, frames_eff};

  assign f_raw     = quo_q[QB-1:0];
  assign f_clamped = (f_raw >= frames_eff) ? frames_m1 : f_raw;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    priority if (cmd_i.advance && !done) begin
      rem_d = '0;
      quo_d = {sum, {FB{1'b0}}};
    end else if (cmd_i.update) begin
      // The quotient stays below frames_eff, so only QB steps are needed.
      rem_d = prod[DW-1:QB];
      quo_d = {prod[QB-1:0], {TB{1'b0}}};
    end else if (cmd_i.div_step) begin
      if (!trial[TB+1]) begin
        rem_d = trial[TB-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[TB-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    accu_d   = accu_q;
    cycles_d = cycles_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    priority if (cmd_i.restart) begin
      accu_d   = '0;
      cycles_d = '0;
      cur_d    = '0;
      prev_d   = '0;
    end else if (cmd_i.advance) begin
      prev_d = cur_q;
      if (done) begin
        accu_d = period_eff;
        cur_d  = frames_m1[FB-1:0];
      end
    end else if (cmd_i.update) begin
      if (finishing) begin
        cycles_d = cycle_limit_q;
        accu_d   = period_eff;
        cur_d    = frames_m1[FB-1:0];
      end else begin
        cycles_d = total_sat;
        accu_d   = rem_q;
      end
    end else if (cmd_i.frame_wr) begin
      cur_d = f_clamped[FB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q  <= (FB + 1)'(1);
      cycle_period_q <= TB'(1);
      cycle_limit_q  <= '0;
      accu_q         <= '0;
      cycles_q       <= '0;
      cur_q          <= '0;
      prev_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          afs_pkg::REG_FRAME_COUNT:  frame_count_q  <= cfg_wdata_i[FB:0];
          afs_pkg::REG_CYCLE_PERIOD: cycle_period_q <= cfg_wdata_i[TB-1:0];
          afs_pkg::REG_CYCLE_LIMIT:  cycle_limit_q  <= cfg_wdata_i[TB-1:0];
          default: ;
        endcase
      end
      accu_q   <= accu_d;
      cycles_q <= cycles_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.out_load) begin
      out_frame_q    <= cur_q;
      out_changed_q  <= (cur_q != prev_q);
      out_finished_q <= done;
    end
  end

  assign status_o.done      = done;
  assign status_o.finishing = finishing;

  assign frame_index_o   = out_frame_q;
  assign frame_changed_o = out_changed_q;
  assign finished_o      = out_finished_q;

endmodule

>>> design/afs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_ctrl: sequencing controller for the animation frame sequencer
// Walks each advance item through the serial divisions that it needs and hands
// every result item to the output register.
// ----------------------------------------------------------------------------
module afs_ctrl #(
  parameter int unsigned TIME_BITS  = afs_pkg::TIME_BITS_DEF,
  parameter int unsigned FRAME_BITS = afs_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_cmd_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  afs_pkg::afs_status_t  status_i,
  output afs_pkg::afs_cmd_t     cmd_o
);

  localparam int unsigned CNT_W = $clog2(TIME_BITS + FRAME_BITS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV1  = 6'b000010,
    S_UPD   = 6'b000100,
    S_DIV2  = 6'b001000,
    S_FRAME = 6'b010000,
    S_LOAD  = 6'b100000
  } afs_state_e;

  afs_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd_i == afs_pkg::CMD_RESTART) begin
            cmd_o.restart = 1'b1;
            state_d       = S_LOAD;
          end else if (in_cmd_i == afs_pkg::CMD_ADVANCE) begin
            cmd_o.advance = 1'b1;
            cnt_d         = CNT_W'(TIME_BITS);
            state_d       = status_i.done ? S_LOAD : S_DIV1;
          end
        end
      end
      S_DIV1: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        cnt_d        = CNT_W'(FRAME_BITS);
        state_d      = status_i.finishing ? S_LOAD : S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_FRAME;
        end
      end
      S_FRAME: begin
        cmd_o.frame_wr = 1'b1;
        state_d        = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/animation_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_sequencer: frame timer for a looping sprite animation
// Adds elapsed ticks to a time accumulator, removes and counts whole cycle
// periods, and reports the current frame, whether it changed and whether the
// cycle limit has been reached.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: elapsed_ticks
//                                                tuser: cmd
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: frame_index,
//                                                frame_changed, finished
// cfg       in   cfg_we_i (no back-pressure)     cfg_idx_i, cfg_wdata_i
//
// The two restoring divisions share one bit-serial divider: TIME_BITS + 1
// steps for the whole-cycle split and FRAME_BITS + 1 steps for the frame
// number. An advance that reaches the cycle limit skips the frame division;
// a restart, or an advance while already finished, skips both divisions.
// The next item is taken only after the last one reaches the output register.
// Reset is asynchronous and active low; it loads frame_count 1, cycle_period
// 1, cycle_limit 0 and clears all animation state. There is no clearing pass.
// The result sits in an output register, so the next item is accepted while
// it waits; only the final hand-off of that next item stalls on m_axis.
//
module animation_frame_sequencer #(
  parameter int unsigned TIME_BITS  = afs_pkg::TIME_BITS_DEF,
  parameter int unsigned FRAME_BITS = afs_pkg::FRAME_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Input items.
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // elapsed_ticks from bit 0, zero padding above.
  input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0]      s_axis_tdata_i,
  // cmd.
  input  logic                                        s_axis_tuser_i,
  // Result items.
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // frame_index from bit 0, then frame_changed, then finished, zero padding.
  output logic [((FRAME_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // Configuration writes.
  input  logic                                        cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [((TIME_BITS > FRAME_BITS + 1) ? TIME_BITS : FRAME_BITS + 1)-1:0]
                                                      cfg_wdata_i
);

  localparam int unsigned OUT_W = ((FRAME_BITS + 2 + 7) / 8) * 8;

  afs_pkg::afs_cmd_t    cmd;
  afs_pkg::afs_status_t status;

  logic [FRAME_BITS-1:0] frame_index;
  logic                  frame_changed;
  logic                  finished;

  // The controller sequences every item; the datapath holds all values.
  afs_ctrl #(
    .TIME_BITS  (TIME_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  afs_datapath #(
    .TIME_BITS  (TIME_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .elapsed_ticks_i (s_axis_tdata_i[TIME_BITS-1:0]),
    .cmd_i           (cmd),
    .status_o        (status),
    .frame_index_o   (frame_index),
    .frame_changed_o (frame_changed),
    .finished_o      (finished)
  );

  // Pack the result item from bit 0 upward and pad with zeros.
  assign m_axis_tdata_o = OUT_W'({finished, frame_changed, frame_index});

endmodule

>>> test/tb_animation_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_animation_frame_sequencer: self-checking bench for the frame sequencer
// Streams advance and restart items through the block under a range of frame
// counts, periods and cycle limits, predicts every result item in the bench
// and compares it field by field, with random gaps on the input side and
// random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_animation_frame_sequencer;

  localparam int unsigned TIME_W      = afs_pkg::TIME_BITS_DEF;
  localparam int unsigned FRAME_W     = afs_pkg::FRAME_BITS_DEF;
  localparam int unsigned MAX_FRAMES  = 1 << FRAME_W;
  localparam int unsigned TICK_MAX    = (1 << TIME_W) - 1;
  // Settle time after each drain; it covers the longest advance with margin.
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_PHASES = 20;
  localparam int unsigned PHASE_ITEMS = 100;
  // Index 3 is not a register; writes to it must leave the block unchanged.
  localparam logic [afs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One input item: the command and the ticks that passed.
  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] ticks;
  } anim_item_t;

  // One result item.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               changed;
    logic               finished;
  } frame_result_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;  // elapsed_ticks [15:0]
  logic        s_axis_tuser_i  = 1'b0; // cmd [0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // frame_index [7:0], frame_changed [8],
                                      // finished [9], zero padding above
  logic                          cfg_we_i    = 1'b0;
  logic [afs_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [15:0]                   cfg_wdata_i = '0;

  animation_frame_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Items waiting to be sent, and results that the predictor says must come.
  anim_item_t    pending_q[$];
  frame_result_t expected_q[$];

  // Idle control: when a burst flag is set, that side never waits.
  bit          src_burst  = 1'b0;
  bit          sink_burst = 1'b0;
  int unsigned src_wait   = 0;
  int unsigned sink_wait  = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Bench copy of the configuration registers, as written.
  logic [8:0]        frame_cnt_cfg = 9'd1;
  logic [TIME_W-1:0] period_cfg    = TIME_W'(1);
  logic [TIME_W-1:0] limit_cfg     = '0;

  // Bench copy of the animation state.
  logic [TIME_W-1:0]  accu_ticks = '0;
  logic [TIME_W-1:0]  cycles_run = '0;
  logic [FRAME_W-1:0] cur_frame  = '0;
  logic [FRAME_W-1:0] prev_frame = '0;

  // The animation is over once a nonzero limit has been reached.
  function automatic bit limit_reached();
    return (limit_cfg != 0) && (cycles_run >= limit_cfg);
  endfunction

  // Applies one item to the bench state and returns the result it causes.
  // Zero frame count and zero period behave as 1; a frame count above the
  // frame range behaves as the full range.
  function automatic frame_result_t sequence_step(logic cmd, logic [TIME_W-1:0] ticks);
    frame_result_t res;
    int unsigned   frames;
    int unsigned   period;
    int unsigned   sum;
    int unsigned   whole;
    int unsigned   rem;
    int unsigned   total;
    int unsigned   idx;
    frames = (frame_cnt_cfg == 0) ? 1 : int'(frame_cnt_cfg);
    if (frames > MAX_FRAMES) frames = MAX_FRAMES;
    period = (period_cfg == 0) ? 1 : int'(period_cfg);
    if (cmd == afs_pkg::CMD_RESTART) begin
      // Restart wipes the animation state and ignores the ticks.
      accu_ticks = '0;
      cycles_run = '0;
      cur_frame  = '0;
      prev_frame = '0;
    end else begin
      prev_frame = cur_frame;
      if (limit_reached()) begin
        // Already finished: park on the last frame, add no time.
        accu_ticks = TIME_W'(period);
        cur_frame  = FRAME_W'(frames - 1);
      end else begin
        sum   = accu_ticks + ticks;
        whole = sum / period;
        rem   = sum % period;
        total = cycles_run + whole;
        if (limit_cfg != 0 && total >= limit_cfg) begin
          // This advance reaches the limit; the count stops exactly on it.
          cycles_run = limit_cfg;
          accu_ticks = TIME_W'(period);
          cur_frame  = FRAME_W'(frames - 1);
        end else begin
          if (total > TICK_MAX) total = TICK_MAX;  // counter saturates
          cycles_run = TIME_W'(total);
          accu_ticks = TIME_W'(rem);
          idx = (rem * frames) / period;
          if (idx >= frames) idx = frames - 1;
          cur_frame = FRAME_W'(idx);
        end
      end
    end
    res.frame    = cur_frame;
    res.changed  = (cur_frame != prev_frame);
    res.finished = limit_reached();
    return res;
  endfunction

  // Input side. The prediction is made at the edge where an item is taken,
  // from the values on the bus, so it always sees the configuration in force.
  always @(posedge clk_i) begin : item_driver
    anim_item_t  nxt;
    int unsigned gap;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_wait        <= 0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_q.push_back(sequence_step(s_axis_tuser_i, s_axis_tdata_i[TIME_W-1:0]));
      gap = src_burst ? 0 : $urandom_range(0, 6);
      if (gap == 0 && pending_q.size() != 0) begin
        // Back-to-back: tvalid stays high, only the payload changes.
        nxt = pending_q.pop_front();
        s_axis_tuser_i <= nxt.cmd;
        s_axis_tdata_i <= nxt.ticks;
      end else begin
        s_axis_tvalid_i <= 1'b0;
        src_wait        <= gap;
      end
    end else if (!s_axis_tvalid_i) begin
      if (src_wait != 0) begin
        src_wait <= src_wait - 1;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        s_axis_tuser_i  <= nxt.cmd;
        s_axis_tdata_i  <= nxt.ticks;
        s_axis_tvalid_i <= 1'b1;
      end
    end
  end

  // Output side. After each result taken, tready may drop for a random number
  // of cycles, so stalls land on every phase of the block's work.
  always @(posedge clk_i) begin : result_monitor
    frame_result_t got;
    frame_result_t want;
    int unsigned   stall;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_wait       <= 0;
    end else if (m_axis_tready_i) begin
      if (m_axis_tvalid_o) begin
        got.frame    = m_axis_tdata_o[FRAME_W-1:0];
        got.changed  = m_axis_tdata_o[FRAME_W];
        got.finished = m_axis_tdata_o[FRAME_W+1];
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with none expected: frame %0d changed %0b finished %0b",
                     $realtime, got.frame, got.changed, got.finished);
        end else begin
          want = expected_q.pop_front();
          if (got.frame !== want.frame || got.changed !== want.changed ||
              got.finished !== want.finished) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: expected frame %0d changed %0b finished %0b, got %0d %0b %0b",
                       $realtime, want.frame, want.changed, want.finished,
                       got.frame, got.changed, got.finished);
          end
        end
        stall = sink_burst ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          m_axis_tready_i <= 1'b0;
          sink_wait       <= stall;
        end
      end
    end else if (sink_wait <= 1) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      sink_wait <= sink_wait - 1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_animation_frame_sequencer failed");
      $finish;
    end
  end

  // Writes the registers selected in which (bit i for register index i) on
  // back-to-back edges, then drops the write enable. Only called while idle.
  task automatic set_config(input bit [2:0] which, input logic [15:0] fcnt,
                            input logic [15:0] per, input logic [15:0] lim);
    if (which[afs_pkg::REG_FRAME_COUNT]) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= afs_pkg::REG_FRAME_COUNT;
      cfg_wdata_i <= fcnt;
      frame_cnt_cfg = fcnt[8:0];
    end
    if (which[afs_pkg::REG_CYCLE_PERIOD]) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= afs_pkg::REG_CYCLE_PERIOD;
      cfg_wdata_i <= per;
      period_cfg = per;
    end
    if (which[afs_pkg::REG_CYCLE_LIMIT]) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= afs_pkg::REG_CYCLE_LIMIT;
      cfg_wdata_i <= lim;
      limit_cfg = lim;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_item(input logic cmd, input logic [TIME_W-1:0] ticks);
    anim_item_t it;
    it.cmd   = cmd;
    it.ticks = ticks;
    pending_q.push_back(it);
  endtask

  // Waits until every item has gone in and every result has come back, then
  // lets the block settle before the next configuration change.
  task automatic drain();
    while (pending_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned eff_per;
    logic [15:0] fcnt;
    logic [15:0] per;
    logic [15:0] lim;
    logic [15:0] ticks;
    bit   [2:0]  which;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: one frame, period of one tick, no limit. Two full-range
    // advances drive the cycle counter into saturation.
    queue_item(afs_pkg::CMD_ADVANCE, 16'd0);
    queue_item(afs_pkg::CMD_ADVANCE, 16'hFFFF);
    queue_item(afs_pkg::CMD_ADVANCE, 16'hFFFF);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd1);
    queue_item(afs_pkg::CMD_RESTART, 16'hFFFF);
    drain();

    // Widest frame count and longest period.
    set_config(3'b111, 16'd256, 16'hFFFF, 16'd0);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd255);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd256);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd65279);
    queue_item(afs_pkg::CMD_ADVANCE, 16'hFFFF);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd0);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd1);
    queue_item(afs_pkg::CMD_RESTART, 16'd0);
    drain();

    // A write to the unused index, then zero frame count and zero period
    // (both act as one) with a short limit: finish step by step, advance
    // while finished, restart, then finish in a single jump.
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_UNUSED;
    cfg_wdata_i <= 16'hFFFF;
    set_config(3'b111, 16'd0, 16'd0, 16'd3);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd1);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd1);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd1);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd5);
    queue_item(afs_pkg::CMD_RESTART, 16'h5A5A);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd7);
    drain();

    // Frame count beyond the frame range, largest limit.
    set_config(3'b111, 16'd511, 16'd1000, 16'hFFFF);
    queue_item(afs_pkg::CMD_RESTART, 16'd0);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd999);
    queue_item(afs_pkg::CMD_ADVANCE, 16'hFFFF);
    drain();

    // Eight frames over 100 ticks with a limit of two: wrap once, finish,
    // then lift the limit mid-run so the kept accumulator is divided again.
    set_config(3'b111, 16'd8, 16'd100, 16'd2);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd50);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd60);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd95);
    drain();
    set_config(3'b100, 16'd0, 16'd0, 16'd0);
    queue_item(afs_pkg::CMD_ADVANCE, 16'd30);
    drain();

    // Random phases. Each one picks a new setting (often only part of it, so
    // the state carries over) and its own idling style.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       fcnt = 16'd0;
      else if (pick < 15) fcnt = 16'd1;
      else if (pick < 25) fcnt = 16'd256;
      else if (pick < 35) fcnt = 16'($urandom_range(257, 511));
      else if (pick < 45) fcnt = 16'($urandom_range(0, 16'hFFFF));
      else                fcnt = 16'($urandom_range(2, 64));

      pick = $urandom_range(0, 99);
      if (pick < 5)       per = 16'd0;
      else if (pick < 10) per = 16'd1;
      else if (pick < 20) per = 16'hFFFF;
      else if (pick < 70) per = 16'($urandom_range(2, 3000));
      else                per = 16'($urandom_range(0, 16'hFFFF));

      pick = $urandom_range(0, 99);
      if (pick < 30)      lim = 16'd0;
      else if (pick < 70) lim = 16'($urandom_range(1, 8));
      else if (pick < 90) lim = 16'($urandom_range(0, 16'hFFFF));
      else                lim = 16'hFFFF;

      which = (ph == 0) ? 3'b111 : 3'($urandom_range(1, 7));
      set_config(which, fcnt, per, lim);
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      eff_per    = (period_cfg == 0) ? 1 : int'(period_cfg);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick  = $urandom_range(0, 99);
        ticks = 16'($urandom_range(0, 16'hFFFF));
        if (pick < 6) begin
          queue_item(afs_pkg::CMD_RESTART, ticks);
        end else begin
          // Mostly steps on the scale of the period, so frames move through
          // the cycle; some edge values and some full-range jumps.
          if (pick < 12)
            ticks = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
          else if (pick < 70)
            ticks = 16'($urandom_range(0, (eff_per > 32767) ? TICK_MAX : 2 * eff_per));
          else if (pick < 80)
            ticks = 16'($urandom_range(0, 3));
          queue_item(afs_pkg::CMD_ADVANCE, ticks);
        end
      end
      drain();
    end

    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("tb_animation_frame_sequencer passed");
    end else begin
      $display("tb_animation_frame_sequencer failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/afs_pkg.sv
design/afs_datapath.sv
design/afs_ctrl.sv
design/animation_frame_sequencer.sv
test/tb_animation_frame_sequencer.sv
